@@ hw/rtl/casl_pkg.sv @@
// Shared types and codes for the set-associative LRU tag cache.
package casl_pkg;

  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int ADDR_FIELD_W = 32;
  localparam int COUNT_W      = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd1;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_STORE   = 2'd1;
  localparam logic [1:0] REQ_MODIFY  = 2'd2;
  localparam logic [1:0] REQ_INVALID = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [ADDR_FIELD_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
    logic [COUNT_W-1:0] evict_count;
  } res_t;

endpackage

@@ hw/rtl/casl_ram.sv @@
// Generic single-port-write, registered-read RAM.
module casl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/casl_lookup.sv @@
// Set lookup: hit way, first free way or LRU victim, and the ageing limit.
module casl_lookup #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32,
  localparam int WIDX  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int LIMW  = $clog2(MAX_WAYS + 1),
  localparam int LINEW = 1 + WIDX + ADDR_WIDTH,
  localparam int ROWW  = MAX_WAYS * LINEW
) (
  input  logic [ROWW-1:0]       row,
  input  logic [ADDR_WIDTH-1:0] tag,
  input  logic [LIMW-1:0]       nw,
  output logic [1:0]            outcome,
  output logic [WIDX-1:0]       way,
  output logic [LIMW-1:0]       limit
);

  import casl_pkg::*;

  logic [MAX_WAYS-1:0]   v;
  logic [WIDX-1:0]       rk [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tg [MAX_WAYS];
  logic                  hit;
  logic                  free;
  logic [WIDX-1:0]       hway;
  logic [WIDX-1:0]       fway;
  logic [WIDX-1:0]       vway;
  logic [WIDX-1:0]       best;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      tg[i] = row[i*LINEW +: ADDR_WIDTH];
      rk[i] = row[i*LINEW + ADDR_WIDTH +: WIDX];
      v[i]  = row[i*LINEW + LINEW - 1];
    end
  end

  always_comb begin
    hit  = 1'b0;
    free = 1'b0;
    hway = '0;
    fway = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < int'(nw) && v[i] && tg[i] == tag) begin
        hit  = 1'b1;
        hway = WIDX'(i);
      end
      if (i < int'(nw) && !v[i]) begin
        free = 1'b1;
        fway = WIDX'(i);
      end
    end
  end

  always_comb begin
    vway = '0;
    best = rk[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (i < int'(nw) && rk[i] > best) begin
        best = rk[i];
        vway = WIDX'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      outcome = OUT_HIT;
      way     = hway;
      limit   = LIMW'(rk[hway]);
    end else if (free) begin
      outcome = OUT_MISS;
      way     = fway;
      limit   = LIMW'(MAX_WAYS);
    end else begin
      outcome = OUT_EVICT;
      way     = vway;
      limit   = LIMW'(best);
    end
  end

endmodule

@@ hw/rtl/casl_update.sv @@
// Set update: recency ageing, fill or replacement of the chosen way.
module casl_update #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32,
  localparam int WIDX  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int LIMW  = $clog2(MAX_WAYS + 1),
  localparam int LINEW = 1 + WIDX + ADDR_WIDTH,
  localparam int ROWW  = MAX_WAYS * LINEW
) (
  input  logic [ROWW-1:0]       row,
  input  logic [ADDR_WIDTH-1:0] tag,
  input  logic [LIMW-1:0]       nw,
  input  logic [1:0]            outcome,
  input  logic [WIDX-1:0]       way,
  input  logic [LIMW-1:0]       limit,
  output logic [ROWW-1:0]       new_row
);

  import casl_pkg::*;

  localparam logic [WIDX-1:0] RANK_TOP = WIDX'(MAX_WAYS - 1);

  logic                  v;
  logic [WIDX-1:0]       rk;
  logic [ADDR_WIDTH-1:0] tg;

  always_comb begin
    new_row = row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      tg = row[i*LINEW +: ADDR_WIDTH];
      rk = row[i*LINEW + ADDR_WIDTH +: WIDX];
      v  = row[i*LINEW + LINEW - 1];
      if (i < int'(nw)) begin
        if (WIDX'(i) == way) begin
          rk = '0;
          if (outcome != OUT_HIT) begin
            tg = tag;
          end
          if (outcome == OUT_MISS) begin
            v = 1'b1;
          end
        end else if (v && LIMW'(rk) < limit && rk < RANK_TOP) begin
          rk = rk + WIDX'(1);
        end
      end
      new_row[i*LINEW +: LINEW] = {v, rk, tg};
    end
  end

endmodule

@@ hw/rtl/set_assoc_cache_lru_tag_sim.sv @@
// Top level of the set-associative LRU tag cache with its request sequencer.
//
// A request (type and byte address) is taken on a clock edge with start high
// and busy low. The block splits the address into tag and set under the
// current geometry, reads the set's row from the tag RAM, looks it up and
// writes the updated row back. The result (hit, miss and eviction counts) is
// registered on the result port and marked by done, high for a single cycle.
// Load or store: accept, RAM read, lookup, update, then done; a new start is
// taken in the same cycle as done. Modify: a second lookup and update run on
// the forwarded row before done. Invalid: done in the next cycle, in which a
// new start can be taken too. Loads, stores and modifies pass through the
// registered read of the tag RAM and separate lookup and update steps.
// Configuration writes go on cfg_we / cfg_index / cfg_data, only while
// idle: a rule for the user that the block does not enforce. Reset restores
// the default geometry and marks every set empty through one flag per set;
// no clearing pass is needed. The receiver cannot stall.
module set_assoc_cache_lru_tag_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  casl_pkg::req_t              req,
  output logic                        busy,
  output logic                        done,
  output casl_pkg::res_t              result,
  input  logic                        cfg_we,
  input  logic [casl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [casl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import casl_pkg::*;

  localparam int SETW  = MAX_SET_BITS;
  localparam int NSETS = 1 << SETW;
  localparam int WIDX  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LIMW  = $clog2(MAX_WAYS + 1);
  localparam int LINEW = 1 + WIDX + ADDR_WIDTH;
  localparam int ROWW  = MAX_WAYS * LINEW;
  localparam int SBW   = $clog2(MAX_SET_BITS + 1);
  localparam int SHW   = $clog2(MAX_SET_BITS + 32);
  localparam int EXTW  = (ADDR_WIDTH > ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]              state;
  logic [SET_BITS_W-1:0]   set_bits;
  logic [WAYS_W-1:0]       ways;
  logic [BLOCK_BITS_W-1:0] block_bits;

  logic [1:0]            type_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [SETW-1:0]       set_q;
  logic                  second;
  logic                  rok_q;
  logic [NSETS-1:0]      row_ok;
  logic [ROWW-1:0]       row_q;
  logic [1:0]            outcome_q;
  logic [WIDX-1:0]       way_q;
  logic [LIMW-1:0]       limit_q;
  logic [COUNT_W-1:0]    hits;
  logic [COUNT_W-1:0]    misses;
  logic [COUNT_W-1:0]    evicts;
  logic [COUNT_W-1:0]    hits_next;
  logic [COUNT_W-1:0]    misses_next;
  logic [COUNT_W-1:0]    evicts_next;

  logic [SBW-1:0]        sb;
  logic [LIMW-1:0]       nw;
  logic [SHW-1:0]        shift;
  logic [EXTW-1:0]       addr_ext;
  logic [ADDR_WIDTH-1:0] addr_w;
  logic [ADDR_WIDTH-1:0] tag_in;
  logic [ADDR_WIDTH-1:0] addr_sh;
  logic [SETW-1:0]       set_mask;
  logic [SETW-1:0]       set_in;
  logic                  accept;

  logic [ROWW-1:0] rdata;
  logic [ROWW-1:0] lk_row;
  logic [ROWW-1:0] new_row;
  logic [1:0]      lk_outcome;
  logic [WIDX-1:0] lk_way;
  logic [LIMW-1:0] lk_limit;
  logic            ram_we;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign ram_we = (state == S_UPD);

  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb = SBW'(MAX_SET_BITS);
    end else begin
      sb = SBW'(set_bits);
    end
    if (ways == '0) begin
      nw = LIMW'(1);
    end else if (int'(ways) > MAX_WAYS) begin
      nw = LIMW'(MAX_WAYS);
    end else begin
      nw = LIMW'(ways);
    end
    shift    = SHW'(sb) + SHW'(block_bits);
    addr_ext = EXTW'(req.address);
    addr_w   = addr_ext[ADDR_WIDTH-1:0];
    tag_in   = addr_w >> shift;
    addr_sh  = addr_w >> block_bits;
    for (int i = 0; i < SETW; i++) begin
      set_mask[i] = (i < int'(sb));
    end
    set_in = SETW'(addr_sh) & set_mask;
  end

  assign lk_row = second ? row_q : (rok_q ? rdata : '0);

  casl_ram #(
    .WIDTH(ROWW),
    .DEPTH(NSETS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(set_q),
    .wdata(new_row),
    .re   (state == S_RD),
    .raddr(set_q),
    .rdata(rdata)
  );

  casl_lookup #(
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_lookup (
    .row    (lk_row),
    .tag    (tag_q),
    .nw     (nw),
    .outcome(lk_outcome),
    .way    (lk_way),
    .limit  (lk_limit)
  );

  casl_update #(
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_update (
    .row    (row_q),
    .tag    (tag_q),
    .nw     (nw),
    .outcome(outcome_q),
    .way    (way_q),
    .limit  (limit_q),
    .new_row(new_row)
  );

  always_comb begin
    hits_next   = hits;
    misses_next = misses;
    evicts_next = evicts;
    if (outcome_q == OUT_HIT) begin
      hits_next = hits + COUNT_W'(1);
    end else begin
      misses_next = misses + COUNT_W'(1);
      if (outcome_q == OUT_EVICT) begin
        evicts_next = evicts + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= SET_BITS_RST;
      ways       <= WAYS_RST;
      block_bits <= BLOCK_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits   <= cfg_data[SET_BITS_W-1:0];
        CFG_WAYS:       ways       <= cfg_data[WAYS_W-1:0];
        CFG_BLOCK_BITS: block_bits <= cfg_data[BLOCK_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      second <= 1'b0;
      row_ok <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && req.req_type == REQ_INVALID) begin
            done   <= 1'b1;
            result <= '0;
          end else begin
            done <= 1'b0;
            if (accept) begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          done  <= 1'b0;
          state <= S_LOOK;
        end
        S_LOOK: begin
          done  <= 1'b0;
          state <= S_UPD;
        end
        S_UPD: begin
          row_ok[set_q] <= 1'b1;
          if (type_q == REQ_MODIFY && !second) begin
            done   <= 1'b0;
            second <= 1'b1;
            state  <= S_LOOK;
          end else begin
            second             <= 1'b0;
            done               <= 1'b1;
            result.hit_count   <= hits_next;
            result.miss_count  <= misses_next;
            result.evict_count <= evicts_next;
            state              <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_q <= req.req_type;
      tag_q  <= tag_in;
      set_q  <= set_in;
      hits   <= '0;
      misses <= '0;
      evicts <= '0;
    end
    if (state == S_RD) begin
      rok_q <= row_ok[set_q];
    end
    if (state == S_LOOK) begin
      row_q     <= lk_row;
      outcome_q <= lk_outcome;
      way_q     <= lk_way;
      limit_q   <= lk_limit;
    end
    if (state == S_UPD) begin
      row_q  <= new_row;
      hits   <= hits_next;
      misses <= misses_next;
      evicts <= evicts_next;
    end
  end

endmodule
